### rtl/tsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_pkg: shared types and constants for the texture slot batcher
// Field widths, default sizes, the controller state type and the control
// word that the controller broadcasts to the slot cells.
// ----------------------------------------------------------------------------
package tsb_pkg;

  // Field widths of the input and result words
  localparam int TEX_ID_W     = 32;
  localparam int OUT_SLOT_W   = 4;
  localparam int OUT_BATCH_W  = 6;
  localparam int OUT_RECT_W   = 16;

  // Default sizes
  localparam int DEF_TEX_SLOTS   = 16;
  localparam int DEF_MAX_BATCHES = 64;
  localparam int DEF_MAX_RECTS   = 65536;

  // Controller states
  typedef enum logic [0:0] {
    TSB_IDLE,
    TSB_LOOKUP
  } tsb_state_t;

  // Control broadcast to every slot cell
  typedef struct packed {
    logic cmp;  // capture the compare result against the incoming id
    logic wr;   // write the held id into the selected cell
    logic clr;  // drop all entries (new batch)
  } tsb_cell_ctl_t;

endpackage

### rtl/tsb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_cell: one texture slot of the current batch
// Holds one texture id and its used flag, registers a hit against the
// incoming id, and passes the first-hit chain on to the next cell.
// ----------------------------------------------------------------------------
module tsb_cell #(
  parameter int SLOT_W = 4,
  parameter int IDX    = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsb_pkg::tsb_cell_ctl_t        ctl,
  input  logic [tsb_pkg::TEX_ID_W-1:0]  cmp_id,
  input  logic [tsb_pkg::TEX_ID_W-1:0]  wr_id,
  input  logic [SLOT_W-1:0]             wr_idx,
  input  logic                          found_in,
  input  logic [SLOT_W-1:0]             idx_in,
  output logic                          found_out,
  output logic [SLOT_W-1:0]             idx_out
);

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);

  logic [tsb_pkg::TEX_ID_W-1:0] id_r;
  logic                         used_r, used_nxt;
  logic                         hit_r, hit_nxt;
  logic                         sel;
  logic                         first;

  assign sel = ctl.wr && (wr_idx == MY_IDX);

  // Used flag: cleared on a new batch, set when written
  always_comb begin
    used_nxt = used_r;
    if (ctl.clr) begin
      used_nxt = sel;
    end else if (sel) begin
      used_nxt = 1'b1;
    end
  end

  // Hit flag captured when a word is taken in
  always_comb begin
    hit_nxt = hit_r;
    if (ctl.cmp) begin
      hit_nxt = used_r && (id_r == cmp_id);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      hit_r  <= hit_nxt;
    end
  end

  // Stored id, no reset needed
  always_ff @(posedge clk) begin
    if (sel) begin
      id_r <= wr_id;
    end
  end

  // First-hit chain toward the higher slots
  assign first     = hit_r && !found_in;
  assign found_out = found_in || hit_r;
  assign idx_out   = first ? MY_IDX : idx_in;

endmodule

### rtl/texture_slot_batcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_slot_batcher: assigns texture slots and batches to rectangles
// Looks a texture id up in the current batch's slot cells, appends it to a free
// slot or opens a new batch when every slot is taken, and flags overflow.
// ----------------------------------------------------------------------------
//  Channel  Ports                                          Direction
//  in       in_valid, in_stall, in_tex_id                  word in
//  out      out_valid, out_stall, out_slot, out_batch_num, word out
//           out_opened_batch, out_batch_first_rect,
//           out_rect_num, out_overflow
//
//  Each word is compared in every slot cell when it is taken; then, in the
//  lookup state, the first hit is resolved through the cell chain and the state updated.
//  A stalled result holds in the output register; the next word is taken
//  while it waits and its lookup finishes once the register frees up.
//  Reset (rst_n, synchronous) empties the slot cells and zeroes the batch
//  and rectangle counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module texture_slot_batcher #(
  parameter int TEX_SLOTS   = tsb_pkg::DEF_TEX_SLOTS,
  parameter int MAX_BATCHES = tsb_pkg::DEF_MAX_BATCHES,
  parameter int MAX_RECTS   = tsb_pkg::DEF_MAX_RECTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tsb_pkg::TEX_ID_W-1:0]     in_tex_id,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tsb_pkg::OUT_SLOT_W-1:0]   out_slot,
  output logic [tsb_pkg::OUT_BATCH_W-1:0]  out_batch_num,
  output logic                             out_opened_batch,
  output logic [tsb_pkg::OUT_RECT_W-1:0]   out_batch_first_rect,
  output logic [tsb_pkg::OUT_RECT_W-1:0]   out_rect_num,
  output logic                             out_overflow
);

  localparam int SLOT_W  = (TEX_SLOTS > 1) ? $clog2(TEX_SLOTS) : 1;
  localparam int SU_W    = $clog2(TEX_SLOTS + 1);
  localparam int BATCH_W = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
  localparam int RECT_W  = $clog2(MAX_RECTS + 1);
  localparam int OS_W    = tsb_pkg::OUT_SLOT_W;
  localparam int OB_W    = tsb_pkg::OUT_BATCH_W;
  localparam int OR_W    = tsb_pkg::OUT_RECT_W;

  localparam logic [SU_W-1:0]    SLOTS_FULL = SU_W'(TEX_SLOTS);
  localparam logic [BATCH_W-1:0] LAST_BATCH = BATCH_W'(MAX_BATCHES - 1);
  localparam logic [RECT_W-1:0]  RECTS_FULL = RECT_W'(MAX_RECTS);

  // State
  tsb_pkg::tsb_state_t            state_r, state_nxt;
  logic [tsb_pkg::TEX_ID_W-1:0]   tex_id_r;
  logic [SU_W-1:0]                slots_used_r, slots_used_nxt;
  logic [BATCH_W-1:0]             cur_batch_r, cur_batch_nxt;
  logic [RECT_W-1:0]              batch_start_r, batch_start_nxt;
  logic [RECT_W-1:0]              rect_count_r, rect_count_nxt;

  // Output register
  logic                           out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]              o_slot_r, o_slot_nxt;
  logic [BATCH_W-1:0]             o_batch_r, o_batch_nxt;
  logic                           o_opened_r, o_opened_nxt;
  logic [RECT_W-1:0]              o_start_r, o_start_nxt;
  logic [RECT_W-1:0]              o_rect_r, o_rect_nxt;
  logic                           o_ovf_r, o_ovf_nxt;

  // Cell chain
  tsb_pkg::tsb_cell_ctl_t         ctl;
  logic [SLOT_W-1:0]              wr_idx;
  logic [TEX_SLOTS:0]             found_c;
  logic [SLOT_W-1:0]              idx_c [TEX_SLOTS+1];

  logic in_take, out_free;
  logic found, full, ovf_rect, need_new, ovf, opened;

  assign found_c[0] = 1'b0;
  assign idx_c[0]   = '0;

  genvar g;
  generate
    for (g = 0; g < TEX_SLOTS; g++) begin : g_cell
      tsb_cell #(
        .SLOT_W (SLOT_W),
        .IDX    (g)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cmp_id    (in_tex_id),
        .wr_id     (tex_id_r),
        .wr_idx    (wr_idx),
        .found_in  (found_c[g]),
        .idx_in    (idx_c[g]),
        .found_out (found_c[g+1]),
        .idx_out   (idx_c[g+1])
      );
    end
  endgenerate

  assign in_stall = (state_r != tsb_pkg::TSB_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Lookup decision
  assign found    = found_c[TEX_SLOTS];
  assign full     = (slots_used_r == SLOTS_FULL);
  assign ovf_rect = (rect_count_r == RECTS_FULL);
  assign need_new = !found && full;
  assign ovf      = ovf_rect || (need_new && (cur_batch_r == LAST_BATCH));
  assign opened   = !ovf && need_new;
  assign wr_idx   = opened ? '0 : slots_used_r[SLOT_W-1:0];

  // Next state, cell control and result
  always_comb begin
    state_nxt       = state_r;
    slots_used_nxt  = slots_used_r;
    cur_batch_nxt   = cur_batch_r;
    batch_start_nxt = batch_start_r;
    rect_count_nxt  = rect_count_r;
    out_valid_nxt   = out_valid_r && out_stall;
    o_slot_nxt      = o_slot_r;
    o_batch_nxt     = o_batch_r;
    o_opened_nxt    = o_opened_r;
    o_start_nxt     = o_start_r;
    o_rect_nxt      = o_rect_r;
    o_ovf_nxt       = o_ovf_r;
    ctl.cmp         = 1'b0;
    ctl.wr          = 1'b0;
    ctl.clr         = 1'b0;
    unique case (state_r)
      tsb_pkg::TSB_IDLE: begin
        if (in_take) begin
          ctl.cmp   = 1'b1;
          state_nxt = tsb_pkg::TSB_LOOKUP;
        end
      end
      tsb_pkg::TSB_LOOKUP: begin
        if (out_free) begin
          state_nxt     = tsb_pkg::TSB_IDLE;
          out_valid_nxt = 1'b1;
          o_rect_nxt    = rect_count_r;
          o_ovf_nxt     = ovf;
          o_opened_nxt  = opened;
          if (ovf) begin
            o_slot_nxt  = '0;
            o_batch_nxt = cur_batch_r;
            o_start_nxt = batch_start_r;
          end else begin
            rect_count_nxt = rect_count_r + 1'b1;
            if (found) begin
              o_slot_nxt = idx_c[TEX_SLOTS];
            end else begin
              ctl.wr         = 1'b1;
              o_slot_nxt     = wr_idx;
              slots_used_nxt = opened ? SU_W'(1) : slots_used_r + 1'b1;
            end
            if (opened) begin
              ctl.clr         = 1'b1;
              cur_batch_nxt   = cur_batch_r + 1'b1;
              batch_start_nxt = rect_count_r;
            end
            o_batch_nxt = opened ? cur_batch_r + 1'b1 : cur_batch_r;
            o_start_nxt = opened ? rect_count_r : batch_start_r;
          end
        end
      end
      default: state_nxt = tsb_pkg::TSB_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tsb_pkg::TSB_IDLE;
      slots_used_r  <= '0;
      cur_batch_r   <= '0;
      batch_start_r <= '0;
      rect_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      slots_used_r  <= slots_used_nxt;
      cur_batch_r   <= cur_batch_nxt;
      batch_start_r <= batch_start_nxt;
      rect_count_r  <= rect_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      tex_id_r <= in_tex_id;
    end
    o_slot_r   <= o_slot_nxt;
    o_batch_r  <= o_batch_nxt;
    o_opened_r <= o_opened_nxt;
    o_start_r  <= o_start_nxt;
    o_rect_r   <= o_rect_nxt;
    o_ovf_r    <= o_ovf_nxt;
  end

  // Result fields: low bits of each value, zero-extended where narrower
  logic [SLOT_W+OS_W-1:0]  slot_ext;
  logic [BATCH_W+OB_W-1:0] batch_ext;
  logic [RECT_W+OR_W-1:0]  start_ext;
  logic [RECT_W+OR_W-1:0]  rect_ext;

  assign slot_ext  = {{OS_W{1'b0}}, o_slot_r};
  assign batch_ext = {{OB_W{1'b0}}, o_batch_r};
  assign start_ext = {{OR_W{1'b0}}, o_start_r};
  assign rect_ext  = {{OR_W{1'b0}}, o_rect_r};

  assign out_valid            = out_valid_r;
  assign out_slot             = slot_ext[OS_W-1:0];
  assign out_batch_num        = batch_ext[OB_W-1:0];
  assign out_opened_batch     = o_opened_r;
  assign out_batch_first_rect = start_ext[OR_W-1:0];
  assign out_rect_num         = rect_ext[OR_W-1:0];
  assign out_overflow         = o_ovf_r;

endmodule

### test/texture_slot_batcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_slot_batcher_tb: self-checking bench for the texture slot batcher
// Feeds texture ids through the valid/stall input channel. A ledger class
// tracks the slot table, batch and rectangle counters alongside the block and
// checks every result word field by field. The run walks through directed
// corner ids, random ids drawn from a small working set, then exhausts the
// batches and probes the last batch with reused and rejected ids.
// ----------------------------------------------------------------------------
module texture_slot_batcher_tb;

  localparam int TEX_ID_W    = tsb_pkg::TEX_ID_W;
  localparam int OUT_SLOT_W  = tsb_pkg::OUT_SLOT_W;
  localparam int OUT_BATCH_W = tsb_pkg::OUT_BATCH_W;
  localparam int OUT_RECT_W  = tsb_pkg::OUT_RECT_W;

  localparam int SLOTS    = tsb_pkg::DEF_TEX_SLOTS;
  localparam int BATCHES  = tsb_pkg::DEF_MAX_BATCHES;
  localparam int RECTS    = tsb_pkg::DEF_MAX_RECTS;
  localparam int RAND_N   = 1400;
  localparam int LAST_N   = 100;
  localparam int POOL_N   = 20;
  localparam int IDLE_PCT = 11;

  // One result word as the block presents it
  typedef struct packed {
    logic [OUT_SLOT_W-1:0]  slot;
    logic [OUT_BATCH_W-1:0] batch_num;
    logic                   opened_batch;
    logic [OUT_RECT_W-1:0]  batch_first_rect;
    logic [OUT_RECT_W-1:0]  rect_num;
    logic                   overflow;
  } rect_bind_t;

  // Tracks batch/slot state and the binding each accepted rectangle should get
  class batch_ledger;
    logic [TEX_ID_W-1:0] slot_ids[SLOTS];
    logic [4:0]          slots_used;
    logic [5:0]          cur_batch;
    logic [15:0]         cur_batch_start;
    logic [16:0]         rect_count;
    rect_bind_t          due_binds[$];
    int                  fails;
    int                  checked;
    int                  rejects;
    int                  openings;

    function new();
      foreach (slot_ids[i]) slot_ids[i] = '0;
      slots_used      = '0;
      cur_batch       = '0;
      cur_batch_start = '0;
      rect_count      = '0;
      fails           = 0;
      checked         = 0;
      rejects         = 0;
      openings        = 0;
    endfunction

    // Accepted input word: work out its binding and advance the state
    function void note_rect(logic [TEX_ID_W-1:0] id);
      rect_bind_t want;
      bit         hit;
      int         s;
      int         i;
      want = '0;
      hit  = 1'b0;
      s    = 0;
      if (int'(rect_count) >= RECTS) begin
        want.overflow = 1'b1;
      end else begin
        for (i = 0; i < int'(slots_used) && i < SLOTS; i++) begin
          if (!hit && slot_ids[i] == id) begin
            hit = 1'b1;
            s   = i;
          end
        end
        if (!hit && int'(slots_used) >= SLOTS) begin
          if (int'(cur_batch) + 1 >= BATCHES) want.overflow = 1'b1;
          else want.opened_batch = 1'b1;
        end
      end

      if (!want.overflow) begin
        if (!hit) begin
          // full table: start a fresh batch at this rectangle
          if (want.opened_batch) begin
            cur_batch       = cur_batch + 1'b1;
            cur_batch_start = rect_count[15:0];
            slots_used      = '0;
            foreach (slot_ids[i]) slot_ids[i] = '0;
            openings++;
          end
          s = int'(slots_used);
          slot_ids[s] = id;
          slots_used  = slots_used + 1'b1;
        end
        want.slot = s[OUT_SLOT_W-1:0];
      end else begin
        rejects++;
      end
      want.batch_num        = cur_batch;
      want.batch_first_rect = cur_batch_start;
      want.rect_num         = rect_count[15:0];
      if (!want.overflow) rect_count = rect_count + 1'b1;
      due_binds.push_back(want);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        fails++;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    // Accepted result word: compare with the oldest pending binding
    function void check_bind(rect_bind_t got);
      rect_bind_t want;
      if (due_binds.size() == 0) begin
        fails++;
        $error("result word with no pending rectangle");
        return;
      end
      want = due_binds.pop_front();
      checked++;
      cmp_field("slot", want.slot, got.slot);
      cmp_field("batch_num", want.batch_num, got.batch_num);
      cmp_field("opened_batch", want.opened_batch, got.opened_batch);
      cmp_field("batch_first_rect", want.batch_first_rect, got.batch_first_rect);
      cmp_field("rect_num", want.rect_num, got.rect_num);
      cmp_field("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [TEX_ID_W-1:0]    in_tex_id;
  logic                   out_valid;
  logic                   out_stall;
  logic [OUT_SLOT_W-1:0]  out_slot;
  logic [OUT_BATCH_W-1:0] out_batch_num;
  logic                   out_opened_batch;
  logic [OUT_RECT_W-1:0]  out_batch_first_rect;
  logic [OUT_RECT_W-1:0]  out_rect_num;
  logic                   out_overflow;

  batch_ledger ledger = new();
  bit          steady;
  logic [TEX_ID_W-1:0] pool[POOL_N];

  texture_slot_batcher i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_tex_id            (in_tex_id),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_slot             (out_slot),
    .out_batch_num        (out_batch_num),
    .out_opened_batch     (out_opened_batch),
    .out_batch_first_rect (out_batch_first_rect),
    .out_rect_num         (out_rect_num),
    .out_overflow         (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net against a hung handshake
  initial begin
    #50000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: check accepted words, stall at random
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0)
        ledger.check_bind('{out_slot, out_batch_num, out_opened_batch,
                            out_batch_first_rect, out_rect_num, out_overflow});
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Present one id, holding it until the block takes the word
  task automatic push_rect(input logic [TEX_ID_W-1:0] id);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_tex_id <= id;
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.note_rect(id);
  endtask

  // Drop valid and hold off until every pending result has come back
  task automatic drain;
    in_valid <= 1'b0;
    while (ledger.due_binds.size() != 0) @(posedge clk);
  endtask

  function automatic logic [TEX_ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 68) return pool[$urandom_range(0, POOL_N - 1)];
    // near miss: one bit away from a working-set id
    if (r < 80) return pool[$urandom_range(0, POOL_N - 1)] ^ (32'h1 << $urandom_range(0, 31));
    if (r < 92) return $urandom();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return ~(32'h1 << $urandom_range(0, 31));
    endcase
  endfunction

  initial begin
    in_valid  <= 1'b0;
    in_tex_id <= '0;
    rst_n     <= 1'b0;
    steady    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero id vs. cleared table, all-ones, hits, fill, new batch
    push_rect(32'h0000_0000);
    push_rect(32'h0000_0000);
    push_rect(32'hFFFF_FFFF);
    push_rect(32'h0000_0000);
    push_rect(32'hFFFF_FFFF);
    push_rect(32'h8000_0000);
    push_rect(32'h0000_0001);
    push_rect(32'hFFFF_FFFE);
    push_rect(32'hA5A5_A5A5);
    push_rect(32'h5A5A_5A5A);
    for (int k = 0; k < 9; k++) push_rect(32'h1000_0000 + k);
    push_rect(32'h1000_0008);
    push_rect(32'h7FFF_FFFF);
    push_rect(32'h0000_0000);
    drain();

    // Random ids from a rotating working set
    for (int n = 0; n < RAND_N; n++) begin
      if (n % 120 == 0)
        foreach (pool[i]) pool[i] = $urandom();
      steady = (n >= 700 && n < 1000);
      push_rect(pick_id());
    end
    steady = 1'b0;
    drain();

    // Use up the batches with fresh ids
    while (int'(ledger.cur_batch) < BATCHES - 1 || int'(ledger.slots_used) < SLOTS)
      push_rect($urandom());

    // Last batch: reuse its ids, with some new ids that get rejected
    for (int n = 0; n < LAST_N; n++) begin
      if ($urandom_range(0, 9) == 0) push_rect($urandom());
      else push_rect(ledger.slot_ids[$urandom_range(0, SLOTS - 1)]);
    end
    drain();
    repeat (20) @(posedge clk);

    $display("checked %0d result words: %0d batch openings, %0d rejected words",
             ledger.checked, ledger.openings, ledger.rejects);
    $display("ran the batches to exhaustion and probed the last batch");
    if (ledger.fails == 0 && ledger.due_binds.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
